>>> rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int WORD_W        = 32;
  localparam int CMD_W         = 4;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_CMP     = 4'd4,
    CMD_INC     = 4'd5,
    CMD_DEC     = 4'd6,
    CMD_TOINT   = 4'd7,
    CMD_FROMINT = 4'd8
  } cmd_t;

  // item data that rides alongside the divider stages
  typedef struct packed {
    logic [WORD_W-1:0] res;     // result for every command except div
    logic              gt;
    logic              lt;
    logic              eq;
    logic              is_div;
    logic              neg;     // quotient sign
    logic              dz;
  } side_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              gt;
    logic              lt;
    logic              eq;
    logic              dz;
  } result_t;

endpackage

>>> rtl/fpa_front.sv
module fpa_front #(
  parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [fpa_pkg::CMD_W-1:0]                 cmd_in,
  input  logic signed [fpa_pkg::WORD_W-1:0]         a_in,
  input  logic signed [fpa_pkg::WORD_W-1:0]         b_in,
  output logic                                      out_valid,
  output fpa_pkg::side_t                            side,
  output logic [fpa_pkg::WORD_W+FRACTION_BITS-1:0]  dvd,
  output logic [fpa_pkg::WORD_W-1:0]                dsr
);
  import fpa_pkg::*;

  // stage A: operand capture and full product
  logic                           va;
  cmd_t                           cmd_a;
  logic signed [WORD_W-1:0]       a_a;
  logic signed [WORD_W-1:0]       b_a;
  logic signed [2*WORD_W-1:0]     prod_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_a  <= cmd_t'(cmd_in);
      a_a    <= a_in;
      b_a    <= b_in;
      prod_a <= a_in * b_in;
    end
  end

  // stage B: result select, flags, divider operand magnitudes
  side_t                     side_c;
  logic [WORD_W-1:0]         a_mag;
  logic [WORD_W-1:0]         b_mag;

  always_comb begin
    side_c = '0;
    unique case (cmd_a)
      CMD_ADD:     side_c.res = a_a + b_a;
      CMD_SUB:     side_c.res = a_a - b_a;
      CMD_MUL:     side_c.res = prod_a[FRACTION_BITS+WORD_W-1:FRACTION_BITS];
      CMD_DIV:     side_c.res = '0;
      CMD_CMP:     side_c.res = '0;
      CMD_INC:     side_c.res = a_a + WORD_W'(1);
      CMD_DEC:     side_c.res = a_a - WORD_W'(1);
      CMD_TOINT:   side_c.res = a_a >>> FRACTION_BITS;
      CMD_FROMINT: side_c.res = a_a << FRACTION_BITS;
      default:     side_c.res = '0;
    endcase
    side_c.gt     = a_a > b_a;
    side_c.lt     = a_a < b_a;
    side_c.eq     = a_a == b_a;
    side_c.is_div = cmd_a == CMD_DIV;
    side_c.dz     = (cmd_a == CMD_DIV) && (b_a == '0);
    side_c.neg    = a_a[WORD_W-1] ^ b_a[WORD_W-1];
  end

  // magnitude of the most negative value still fits unsigned
  assign a_mag = a_a[WORD_W-1] ? WORD_W'(-a_a) : WORD_W'(a_a);
  assign b_mag = b_a[WORD_W-1] ? WORD_W'(-b_a) : WORD_W'(b_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= side_c;
      dvd  <= {a_mag, {FRACTION_BITS{1'b0}}};
      dsr  <= b_mag;
    end
  end

endmodule

>>> rtl/fpa_div_stage.sv
module fpa_div_stage #(
  parameter int DVD_W = fpa_pkg::WORD_W + fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  fpa_pkg::side_t                side_in,
  input  logic [fpa_pkg::WORD_W-1:0]    rem_in,
  input  logic [DVD_W-1:0]              dvd_in,
  input  logic [fpa_pkg::WORD_W-1:0]    dsr_in,
  output logic                          out_valid,
  output fpa_pkg::side_t                side_out,
  output logic [fpa_pkg::WORD_W-1:0]    rem_out,
  output logic [DVD_W-1:0]              dvd_out,
  output logic [fpa_pkg::WORD_W-1:0]    dsr_out
);
  import fpa_pkg::*;

  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              qbit;
  logic [WORD_W-1:0] rem_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial    = {rem_in, dvd_in[DVD_W-1]};
  assign diff     = trial - {1'b0, dsr_in};
  assign qbit     = ~diff[WORD_W];
  assign rem_next = qbit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      rem_out  <= rem_next;
      dvd_out  <= {dvd_in[DVD_W-2:0], qbit};
      dsr_out  <= dsr_in;
    end
  end

endmodule

>>> rtl/fpa_out.sv
module fpa_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  fpa_pkg::result_t    in_data,
  output logic                ready,
  output logic                out_valid,
  output fpa_pkg::result_t    out_data,
  input  logic                out_ready
);
  import fpa_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  // pipeline advances only while the skid slot is empty
  assign ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_valid && !out_ready) begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/fixed_point_alu_unit.sv
// channel  | dir | fields (tdata, lowest bit first)
// s_axis   | in  | command[3:0], operand_a[35:4], operand_b[67:36], zero pad
// m_axis   | out | result_value[31:0], is_greater, is_less, is_equal,
//          |     | divide_by_zero, zero pad
//
// One item per cycle while the skid slot is empty. Stages in order: two
// front stages (multiply, select), one restoring divider stage per dividend
// bit (32 + FRACTION_BITS), then the output register.
// rst is synchronous and clears all valid bits; data registers are not reset.
// A result held at m_axis spills into one skid slot; the whole pipeline then
// holds in place until that slot drains, so nothing is dropped or repeated.
module fixed_point_alu_unit #(
  parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // command, operand_a, operand_b, pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result_value, is_greater, is_less, is_equal,
                                 // divide_by_zero, pad
);
  import fpa_pkg::*;

  localparam int DVD_W = WORD_W + FRACTION_BITS;

  logic en;

  logic              v_st   [0:DVD_W];
  side_t             side_st[0:DVD_W];
  logic [WORD_W-1:0] rem_st [0:DVD_W];
  logic [DVD_W-1:0]  dvd_st [0:DVD_W];
  logic [WORD_W-1:0] dsr_st [0:DVD_W];

  assign s_tready  = en;
  assign rem_st[0] = '0;

  fpa_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .cmd_in    (s_tdata[CMD_W-1:0]),
    .a_in      (s_tdata[CMD_W+WORD_W-1:CMD_W]),
    .b_in      (s_tdata[CMD_W+2*WORD_W-1:CMD_W+WORD_W]),
    .out_valid (v_st[0]),
    .side      (side_st[0]),
    .dvd       (dvd_st[0]),
    .dsr       (dsr_st[0])
  );

  for (genvar i = 0; i < DVD_W; i++) begin : g_div
    fpa_div_stage #(
      .DVD_W (DVD_W)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_st[i]),
      .side_in   (side_st[i]),
      .rem_in    (rem_st[i]),
      .dvd_in    (dvd_st[i]),
      .dsr_in    (dsr_st[i]),
      .out_valid (v_st[i+1]),
      .side_out  (side_st[i+1]),
      .rem_out   (rem_st[i+1]),
      .dvd_out   (dvd_st[i+1]),
      .dsr_out   (dsr_st[i+1])
    );
  end

  // final merge: signed quotient, wrapped to the low word
  side_t             side_last;
  logic [WORD_W-1:0] quot;
  result_t           res_c;
  result_t           res_q;

  assign side_last = side_st[DVD_W];
  assign quot      = dvd_st[DVD_W][WORD_W-1:0];

  always_comb begin
    res_c.gt = side_last.gt;
    res_c.lt = side_last.lt;
    res_c.eq = side_last.eq;
    res_c.dz = side_last.dz;
    priority if (!side_last.is_div) begin
      res_c.value = side_last.res;
    end else if (side_last.dz) begin
      res_c.value = '0;
    end else if (side_last.neg) begin
      res_c.value = -quot;
    end else begin
      res_c.value = quot;
    end
  end

  fpa_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_st[DVD_W] && en),
    .in_data   (res_c),
    .ready     (en),
    .out_valid (m_tvalid),
    .out_data  (res_q),
    .out_ready (m_tready)
  );

  assign m_tdata = {4'b0000, res_q.dz, res_q.eq, res_q.lt, res_q.gt, res_q.value};

endmodule
